// ===== design/mfrc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the force response checker.
`timescale 1ns / 1ps

package mfrc_pkg;

	// Frame and channel geometry
	localparam int FRAME_BYTES = 9;
	localparam int CHANNELS    = 2;
	localparam int CH_W        = 1;
	localparam int POS_W       = 4;

	// Byte positions inside a response frame
	localparam logic [POS_W-1:0] POS_ADDR       = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FUNC       = POS_W'(1);
	localparam logic [POS_W-1:0] POS_COUNT      = POS_W'(2);
	localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(3);
	localparam logic [POS_W-1:0] POS_DATA_LAST  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

	// CRC-16/MODBUS, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Fixed byte count of a two-register read response
	localparam logic [7:0] BYTE_COUNT = 8'h04;

	// Register reset values
	localparam logic [7:0] EXP_ADDR_RESET = 8'h01;
	localparam logic [7:0] EXP_FUNC_RESET = 8'h03;

	// APB address width: two 32-bit registers at byte offsets 0 and 4
	localparam int PADDR_W = 3;

	typedef enum logic [0:0] {
		REG_EXP_ADDR = 1'b0,
		REG_EXP_FUNC = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_RX      = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_REQUEST = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [CH_W-1:0]  channel;
		logic [7:0]       rx_byte;
	} in_item_t;

	typedef struct packed {
		logic               frame_done;
		logic               frame_ok;
		logic [CH_W-1:0]    done_channel;
		logic signed [31:0] left_force;
		logic signed [31:0] right_force;
		logic               left_ready;
		logic               right_ready;
	} out_item_t;

	typedef struct packed {
		logic [7:0] expected_address;
		logic [7:0] expected_function;
	} cfg_t;

	// One received byte through the CRC, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/mfrc_cfg.sv =====
// APB register file holding the expected slave address and function code.
`timescale 1ns / 1ps

module mfrc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfrc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output mfrc_pkg::cfg_t               cfg
);
	import mfrc_pkg::*;

	logic [7:0] exp_addr_q;
	logic [7:0] exp_func_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= EXP_ADDR_RESET;
			exp_func_q <= EXP_FUNC_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_EXP_ADDR: exp_addr_q <= pwdata[7:0];
				REG_EXP_FUNC: exp_func_q <= pwdata[7:0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_EXP_ADDR: prdata = {24'h0, exp_addr_q};
			REG_EXP_FUNC: prdata = {24'h0, exp_func_q};
		endcase
	end

	assign cfg.expected_address  = exp_addr_q;
	assign cfg.expected_function = exp_func_q;

endmodule

// ===== design/mfrc_core.sv =====
// Per-channel framing state, CRC check, force latch and result formation.
`timescale 1ns / 1ps

module mfrc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  mfrc_pkg::in_item_t   item,
	input  mfrc_pkg::cfg_t       cfg,
	output mfrc_pkg::out_item_t  res
);
	import mfrc_pkg::*;

	// Channel state
	logic [POS_W-1:0] pos_q   [CHANNELS];
	logic [15:0]      crc_q   [CHANNELS];
	logic             hdr_q   [CHANNELS];
	logic [31:0]      shift_q [CHANNELS];
	logic [31:0]      force_q [CHANNELS];
	logic             ready_q [CHANNELS];

	logic [POS_W-1:0] pos_nx   [CHANNELS];
	logic [15:0]      crc_nx   [CHANNELS];
	logic             hdr_nx   [CHANNELS];
	logic [31:0]      shift_nx [CHANNELS];
	logic [31:0]      force_nx [CHANNELS];
	logic             ready_nx [CHANNELS];

	logic [CH_W-1:0] ch;
	logic [15:0]     crc_new;
	logic            done;
	logic            ok;

	assign ch      = item.channel;
	assign crc_new = crc_byte(crc_q[ch], item.rx_byte);

	// Next state of the addressed channel; the others hold
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			pos_nx[c]   = pos_q[c];
			crc_nx[c]   = crc_q[c];
			hdr_nx[c]   = hdr_q[c];
			shift_nx[c] = shift_q[c];
			force_nx[c] = force_q[c];
			ready_nx[c] = ready_q[c];
		end
		done = 1'b0;
		ok   = 1'b0;

		unique case (item.command)
			CMD_RX: begin
				crc_nx[ch] = crc_new;
				if (pos_q[ch] == POS_ADDR && item.rx_byte != cfg.expected_address) begin
					hdr_nx[ch] = 1'b0;
				end else if (pos_q[ch] == POS_FUNC
						&& item.rx_byte != cfg.expected_function) begin
					hdr_nx[ch] = 1'b0;
				end else if (pos_q[ch] == POS_COUNT && item.rx_byte != BYTE_COUNT) begin
					hdr_nx[ch] = 1'b0;
				end else if (pos_q[ch] >= POS_DATA_FIRST && pos_q[ch] <= POS_DATA_LAST) begin
					shift_nx[ch] = {shift_q[ch][23:0], item.rx_byte};
				end

				if (pos_q[ch] >= POS_LAST) begin
					// frame complete: judge it, then restart framing
					done = 1'b1;
					if (hdr_q[ch] && crc_new == 16'h0000) begin
						ok           = 1'b1;
						force_nx[ch] = shift_q[ch];
						ready_nx[ch] = 1'b1;
					end else begin
						ready_nx[ch] = 1'b0;
					end
					pos_nx[ch]   = '0;
					crc_nx[ch]   = CRC_INIT;
					hdr_nx[ch]   = 1'b1;
					shift_nx[ch] = '0;
				end else begin
					pos_nx[ch] = pos_q[ch] + POS_W'(1);
				end
			end
			CMD_RESTART: begin
				pos_nx[ch]   = '0;
				crc_nx[ch]   = CRC_INIT;
				hdr_nx[ch]   = 1'b1;
				shift_nx[ch] = '0;
			end
			CMD_REQUEST: begin
				ready_nx[ch] = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// State registers, written when the item moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]   <= '0;
				crc_q[c]   <= CRC_INIT;
				hdr_q[c]   <= 1'b1;
				shift_q[c] <= '0;
				force_q[c] <= '0;
				ready_q[c] <= 1'b0;
			end
		end else if (advance) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c]   <= pos_nx[c];
				crc_q[c]   <= crc_nx[c];
				hdr_q[c]   <= hdr_nx[c];
				shift_q[c] <= shift_nx[c];
				force_q[c] <= force_nx[c];
				ready_q[c] <= ready_nx[c];
			end
		end
	end

	// Result reflects state after this item
	assign res.frame_done   = done;
	assign res.frame_ok     = ok;
	assign res.done_channel = ch;
	assign res.left_force   = force_nx[0];
	assign res.right_force  = force_nx[1];
	assign res.left_ready   = ready_nx[0];
	assign res.right_ready  = ready_nx[1];

	// Checks
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
		a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
			pos_q[g] <= POS_LAST)
			else $error("byte position past frame end");

		a_restart: assert property (@(posedge clk) disable iff (!arst_n)
			advance && ch == CH_W'(g) && item.command == CMD_RESTART
			|=> pos_q[g] == '0 && crc_q[g] == CRC_INIT && hdr_q[g])
			else $error("receive error did not restart framing");

		a_accept: assert property (@(posedge clk) disable iff (!arst_n)
			advance && ch == CH_W'(g) && ok
			|=> ready_q[g] && force_q[g] == $past(shift_q[g]) && pos_q[g] == '0)
			else $error("accepted frame not latched");
	end

endmodule

// ===== design/modbus_force_response_checker.sv =====
// Top level: input register, channel core, result register and APB registers.
`timescale 1ns / 1ps

// Checks 9-byte Modbus RTU read-holding-register responses arriving byte by byte on two
// links (left, right). One item enters per clock when the result side keeps up; each item
// gives exactly one result, passing through the input register and then the result
// register. The per-byte CRC-16/MODBUS update and header compare of the addressed channel
// are combinational between those two registers. The input stalls only when both the input
// register and the result register are full and the result is stalled. Expected slave
// address and function code are written over APB at offsets 0x0 and 0x4.
module modbus_force_response_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mfrc_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mfrc_pkg::out_item_t          out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfrc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import mfrc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t res;
	cfg_t      cfg;
	logic      advance;
	logic      in_take;

	// Handshake control
	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	mfrc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	mfrc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Modbus force response checker: directed frames, random traffic.
`timescale 1ns / 1ps

module tb;
	import mfrc_pkg::*;

	localparam int   CYCLE_LIMIT = 200000;
	localparam int   PHASES      = 5;
	localparam int   PHASE_ITEMS = 390;
	localparam cmd_t CMD_UNUSED  = cmd_t'(2'd3);

	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_HI
	} fill_t;

	// One directed row; val doubles as the corruption mask of a CRC high byte
	typedef struct packed {
		cmd_t            cmd;
		logic [CH_W-1:0] ch;
		logic [7:0]      val;
		fill_t           fill;
		logic            typed;
		out_item_t       want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_item;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// Predictor state: per-channel framing plus register copies
	logic [3:0]  frame_pos    [2];
	logic [15:0] frame_crc    [2];
	logic        header_ok    [2];
	logic [31:0] data_shift   [2];
	logic [31:0] force_latch  [2];
	logic        ready_latch  [2];
	logic [7:0]  exp_addr;
	logic [7:0]  exp_func;

	// Random frame builder per channel; index 9 means no frame in flight
	logic [7:0]  frame_buf    [2][9];
	int          frame_idx    [2];

	out_item_t   expected_responses[$];
	logic        calm_stretch = 1'b0;
	int          items_sent, results_seen, frames_passed, frames_failed;
	int          mismatches, cycle_count, settings_used;

	dir_row_t directed [24] = '{
		'{CMD_REQUEST, 1'b0, 8'hA5, FILL_NONE,   1'b1, '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{CMD_UNUSED,  1'b1, 8'h5A, FILL_NONE,   1'b1, '{1'b0, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0, 1'b0}},
		'{CMD_RX,      1'b0, 8'h01, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h03, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h04, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h80, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h00, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h00, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h00, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b0, 8'h00, FILL_CRC_LO, 1'b0, '0},
		'{CMD_RX,      1'b0, 8'h00, FILL_CRC_HI, 1'b1,
			'{1'b1, 1'b1, 1'b0, 32'h80000000, 32'h0, 1'b1, 1'b0}},
		'{CMD_RX,      1'b1, 8'h01, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'h03, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'h04, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'h7F, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'hFF, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'hFF, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'hFF, FILL_NONE,   1'b0, '0},
		'{CMD_RX,      1'b1, 8'h00, FILL_CRC_LO, 1'b0, '0},
		'{CMD_RX,      1'b1, 8'h01, FILL_CRC_HI, 1'b1,
			'{1'b1, 1'b0, 1'b1, 32'h80000000, 32'h0, 1'b1, 1'b0}},
		'{CMD_RX,      1'b1, 8'hFF, FILL_NONE,   1'b0, '0},
		'{CMD_RESTART, 1'b1, 8'h00, FILL_NONE,   1'b0, '0},
		'{CMD_REQUEST, 1'b0, 8'hFF, FILL_NONE,   1'b0, '0},
		'{CMD_RESTART, 1'b0, 8'h3C, FILL_NONE,   1'b0, '0}
	};

	modbus_force_response_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run-length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d responses outstanding", $time,
				expected_responses.size());
			$display("status: fail");
			$finish;
		end
	end

	// Result-side backpressure
	always @(negedge clk) begin
		out_stall <= !calm_stretch && ($urandom_range(99) < 19);
	end

	// CRC-16/MODBUS, one data bit per step
	function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] data);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb  = acc[0] ^ data[i];
			acc = acc >> 1;
			if (fb)
				acc = acc ^ CRC_POLY;
		end
		return acc;
	endfunction

	function automatic void restart_framing(int c);
		frame_pos[c]  = '0;
		frame_crc[c]  = CRC_INIT;
		header_ok[c]  = 1'b1;
		data_shift[c] = '0;
	endfunction

	// Expected response for one accepted item; advances the channel state
	function automatic out_item_t predict_response(in_item_t it);
		out_item_t  r;
		logic [3:0] p;
		int         c;
		c              = int'(it.channel);
		p              = frame_pos[c];
		r              = '0;
		r.done_channel = it.channel;
		case (it.command)
			CMD_RX: begin
				frame_crc[c] = crc16_update(frame_crc[c], it.rx_byte);
				if (p == POS_ADDR && it.rx_byte != exp_addr)
					header_ok[c] = 1'b0;
				else if (p == POS_FUNC && it.rx_byte != exp_func)
					header_ok[c] = 1'b0;
				else if (p == POS_COUNT && it.rx_byte != BYTE_COUNT)
					header_ok[c] = 1'b0;
				else if (p >= POS_DATA_FIRST && p <= POS_DATA_LAST)
					data_shift[c] = {data_shift[c][23:0], it.rx_byte};
				if (p == POS_LAST) begin
					r.frame_done = 1'b1;
					if (header_ok[c] && frame_crc[c] == 16'h0) begin
						r.frame_ok     = 1'b1;
						force_latch[c] = data_shift[c];
						ready_latch[c] = 1'b1;
					end else begin
						ready_latch[c] = 1'b0;
					end
					restart_framing(c);
				end else begin
					frame_pos[c] = p + 4'd1;
				end
			end
			CMD_RESTART: restart_framing(c);
			CMD_REQUEST: ready_latch[c] = 1'b0;
			default: ;
		endcase
		r.left_force  = force_latch[0];
		r.right_force = force_latch[1];
		r.left_ready  = ready_latch[0];
		r.right_ready = ready_latch[1];
		return r;
	endfunction

	// Present one item at the falling edge, hold it until taken
	task automatic send_item(in_item_t it, logic typed, out_item_t want);
		out_item_t pred;
		while (!calm_stretch && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = predict_response(it);
		expected_responses.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// APB write followed by a read back of the same register
	task automatic write_register(reg_idx_t idx, logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {24'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_EXP_ADDR: exp_addr = val;
			REG_EXP_FUNC: exp_func = val;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== val) begin
			mismatches++;
			$display("%0t register %s read: expected %h, got %h", $time, idx.name(), val,
				prdata[7:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Well-formed frame for the current settings, one in four damaged
	function automatic void build_frame(int c);
		logic [31:0] v;
		logic [15:0] sum;
		int          sel, bad, bit_no;
		sel = $urandom_range(7);
		case (sel)
			0:       v = 32'h7FFFFFFF;
			1:       v = 32'h80000000;
			2:       v = 32'h0;
			3:       v = 32'hFFFFFFFF;
			default: v = $urandom;
		endcase
		frame_buf[c][0] = exp_addr;
		frame_buf[c][1] = exp_func;
		frame_buf[c][2] = BYTE_COUNT;
		frame_buf[c][3] = v[31:24];
		frame_buf[c][4] = v[23:16];
		frame_buf[c][5] = v[15:8];
		frame_buf[c][6] = v[7:0];
		bad    = ($urandom_range(3) == 0) ? $urandom_range(8) : -1;
		bit_no = $urandom_range(7);
		// bad header with a matching CRC
		if (bad >= 0 && bad <= 2)
			frame_buf[c][bad][bit_no] = !frame_buf[c][bad][bit_no];
		sum = CRC_INIT;
		for (int k = 0; k < 7; k++)
			sum = crc16_update(sum, frame_buf[c][k]);
		frame_buf[c][7] = sum[7:0];
		frame_buf[c][8] = sum[15:8];
		// damage after the CRC: payload or trailer mismatch
		if (bad >= 3)
			frame_buf[c][bad][bit_no] = !frame_buf[c][bad][bit_no];
		frame_idx[c] = 0;
	endfunction

	// Mostly frame bytes on interleaved channels, some commands and stray bytes
	task automatic random_step();
		in_item_t it;
		int       c, pick;
		c          = $urandom_range(1);
		pick       = $urandom_range(99);
		it.channel = CH_W'(c);
		it.rx_byte = 8'($urandom_range(255));
		it.command = CMD_RX;
		if (pick < 4) begin
			it.command = CMD_REQUEST;
		end else if (pick < 6) begin
			it.command   = CMD_RESTART;
			frame_idx[c] = 9;
		end else if (pick < 8) begin
			it.command = CMD_UNUSED;
		end else if (pick < 10) begin
			// stray byte: frame on this channel is broken
			frame_idx[c] = 9;
		end else begin
			if (frame_idx[c] == 9) begin
				if (frame_pos[c] != POS_ADDR)
					it.command = CMD_RESTART;
				else
					build_frame(c);
			end
			if (it.command == CMD_RX) begin
				it.rx_byte = frame_buf[c][frame_idx[c]];
				frame_idx[c]++;
			end
		end
		send_item(it, 1'b0, '0);
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		mismatches++;
		$display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (out_item.frame_done && out_item.frame_ok)
				frames_passed++;
			else if (out_item.frame_done)
				frames_failed++;
			if (expected_responses.size() == 0) begin
				mismatches++;
				$display("%0t unexpected response: expected none, got %h", $time, out_item);
			end else begin
				want = expected_responses.pop_front();
				if (out_item.frame_done !== want.frame_done)
					report_field("frame_done", 32'(want.frame_done),
						32'(out_item.frame_done));
				if (out_item.frame_ok !== want.frame_ok)
					report_field("frame_ok", 32'(want.frame_ok), 32'(out_item.frame_ok));
				if (out_item.done_channel !== want.done_channel)
					report_field("done_channel", 32'(want.done_channel),
						32'(out_item.done_channel));
				if (out_item.left_force !== want.left_force)
					report_field("left_force", want.left_force, out_item.left_force);
				if (out_item.right_force !== want.right_force)
					report_field("right_force", want.right_force, out_item.right_force);
				if (out_item.left_ready !== want.left_ready)
					report_field("left_ready", 32'(want.left_ready),
						32'(out_item.left_ready));
				if (out_item.right_ready !== want.right_ready)
					report_field("right_ready", 32'(want.right_ready),
						32'(out_item.right_ready));
			end
		end
	end

	// Main sequence
	initial begin
		logic [7:0] addr_set [PHASES];
		logic [7:0] func_set [PHASES];
		logic [7:0] crc_hi_hold;
		in_item_t   it;
		int         c;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_item       = '0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		cycle_count   = 0;
		items_sent    = 0;
		results_seen  = 0;
		frames_passed = 0;
		frames_failed = 0;
		mismatches    = 0;
		settings_used = 1;
		crc_hi_hold   = '0;
		exp_addr      = EXP_ADDR_RESET;
		exp_func      = EXP_FUNC_RESET;
		for (int k = 0; k < 2; k++) begin
			restart_framing(k);
			force_latch[k] = '0;
			ready_latch[k] = 1'b0;
			frame_idx[k]   = 9;
		end
		addr_set = '{8'h00, 8'hFF, 8'h11, 8'($urandom), EXP_ADDR_RESET};
		func_set = '{8'h00, 8'hFF, EXP_FUNC_RESET, 8'($urandom), EXP_FUNC_RESET};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows at reset settings; CRC trailer bytes come from the predictor
		foreach (directed[i]) begin
			c          = int'(directed[i].ch);
			it.command = directed[i].cmd;
			it.channel = directed[i].ch;
			it.rx_byte = directed[i].val;
			case (directed[i].fill)
				FILL_CRC_LO: begin
					it.rx_byte  = frame_crc[c][7:0];
					crc_hi_hold = frame_crc[c][15:8];
				end
				FILL_CRC_HI: it.rx_byte = crc_hi_hold ^ directed[i].val;
				default: ;
			endcase
			send_item(it, directed[i].typed, directed[i].want);
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			in_valid <= 1'b0;
			while (expected_responses.size() != 0)
				@(negedge clk);
			write_register(REG_EXP_ADDR, addr_set[ph]);
			write_register(REG_EXP_FUNC, func_set[ph]);
			@(negedge clk);
			settings_used++;
			calm_stretch = (ph == 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_step();
		end
		calm_stretch = 1'b0;
		in_valid <= 1'b0;

		// Drain
		while (expected_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("%0d items over %0d register settings, %0d responses checked", items_sent,
			settings_used, results_seen);
		$display("frames accepted %0d, rejected %0d, mismatches %0d", frames_passed,
			frames_failed, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== modbus_force_response_checker.f =====
design/mfrc_pkg.sv
design/mfrc_cfg.sv
design/mfrc_core.sv
design/modbus_force_response_checker.sv
dv/tb.sv
